// ----- sv/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
// Used by sfr_cfg, sfr_prefix_unit and stream_find_and_replace.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 4;     // counts 0..8
    localparam int REPL_MAX = 8;
    localparam int ADDR_W   = 5;     // four 64-bit registers at 8*i
    localparam int DATA_W   = 64;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    // Register indexes, taken from paddr[4:3]
    localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // Effective configuration seen by the sequencer
    typedef struct packed {
        logic [DATA_W-1:0] pattern_bytes;
        logic [CNT_W-1:0]  pat_len;      // clamped to 1..MAX_PATTERN
        logic [DATA_W-1:0] repl_bytes;
        logic [CNT_W-1:0]  rep_len;      // clamped to 0..8
    } cfg_t;

endpackage

// ----- sv/sfr_cfg.sv -----
// APB register file for the find-and-replace block.
// Holds pattern and replacement registers; depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_cfg #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic [sfr_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output sfr_pkg::cfg_t             cfg
);
    import sfr_pkg::*;

    logic [DATA_W-1:0] pattern_bytes_reg;
    logic [CNT_W-1:0]  pattern_length_reg;
    logic [DATA_W-1:0] replacement_bytes_reg;
    logic [CNT_W-1:0]  replacement_length_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= CNT_W'(1);
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PATTERN_BYTES:      pattern_bytes_reg      <= pwdata;
                REG_PATTERN_LENGTH:     pattern_length_reg     <= pwdata[CNT_W-1:0];
                REG_REPLACEMENT_BYTES:  replacement_bytes_reg  <= pwdata;
                REG_REPLACEMENT_LENGTH: replacement_length_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back stored values
    always_comb
    begin
        case (reg_idx)
            REG_PATTERN_BYTES:      prdata = pattern_bytes_reg;
            REG_PATTERN_LENGTH:     prdata = DATA_W'(pattern_length_reg);
            REG_REPLACEMENT_BYTES:  prdata = replacement_bytes_reg;
            REG_REPLACEMENT_LENGTH: prdata = DATA_W'(replacement_length_reg);
            default:                prdata = '0;
        endcase
    end

    // Clamp lengths to their usable ranges
    always_comb
    begin
        cfg.pattern_bytes = pattern_bytes_reg;
        cfg.repl_bytes    = replacement_bytes_reg;
        if (pattern_length_reg == '0)
            cfg.pat_len = CNT_W'(1);
        else if (pattern_length_reg > CNT_W'(MAX_PATTERN))
            cfg.pat_len = CNT_W'(MAX_PATTERN);
        else
            cfg.pat_len = pattern_length_reg;
        if (replacement_length_reg > CNT_W'(REPL_MAX))
            cfg.rep_len = CNT_W'(REPL_MAX);
        else
            cfg.rep_len = replacement_length_reg;
    end

endmodule

// ----- sv/sfr_prefix_unit.sv -----
// Shared compare unit: tests whether the first n work bytes are a pattern prefix.
// Used by the sequencer on every decision; depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_prefix_unit #(
    parameter int MAX_PATTERN = 8
) (
    input  logic [MAX_PATTERN-1:0][sfr_pkg::BYTE_W-1:0] work,
    input  logic [sfr_pkg::CNT_W-1:0]                   count,
    input  logic [sfr_pkg::DATA_W-1:0]                  pattern_bytes,
    output logic                                        is_prefix
);
    import sfr_pkg::*;

    logic [MAX_PATTERN-1:0] lane_ok;

    // Compare each lane; lanes at or past count always pass
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            lane_ok[i] = (CNT_W'(i) >= count) ||
                         (work[i] == pattern_bytes[BYTE_W*i +: BYTE_W]);
        end
    end

    assign is_prefix = &lane_ok;

endmodule

// ----- sv/stream_find_and_replace.sv -----
// Top level of the streaming find-and-replace block: sequencer, work buffer,
// output staging. Depends on sfr_pkg, sfr_cfg and sfr_prefix_unit.
`timescale 1ns / 1ps

//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    action, data_byte
//  result    out        result_valid / result_stall out_byte, last
//  config    in/out     APB psel/penable/pwrite    paddr, pwdata, prdata
//
// An item is taken only while the sequencer is idle. A data byte then has the
// bytes released by the rescan and one decision step; a replacement or drain
// emits its bytes and then leaves it, and one closing step follows. Bytes flow
// at one result byte per cycle, set by the single shared prefix compare, while
// the output does not stall. Output stalls hold the sequencer when its staging
// slot is full. Reset clears the held count and sets pattern_length to 1; held
// bytes need no clearing.

module stream_find_and_replace #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       action,
    input  logic [7:0]                 data_byte,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [7:0]                 out_byte,
    output logic                       last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sfr_pkg::ADDR_W-1:0] paddr,
    input  logic [sfr_pkg::DATA_W-1:0] pwdata,
    output logic [sfr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import sfr_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_REPL   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    cfg_t cfg;

    logic [2:0]                         state_reg, state_next;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] work_reg, work_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               nl_reg, nl_next;
    logic [CNT_W-1:0]                   ri_reg, ri_next;
    logic [CNT_W-1:0]                   emit_cnt_reg, emit_cnt_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [BYTE_W-1:0]                  pend_byte_reg, pend_byte_next;
    logic                               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]                  out_byte_reg, out_byte_next;
    logic                               out_last_reg, out_last_next;

    logic              is_prefix;
    logic              slot_free;
    logic              emit_want;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_ok;
    logic              advance;
    logic              out_load;
    logic              out_load_last;
    logic              accept;
    logic              stale;

    sfr_cfg #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfr_prefix_unit #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_prefix (
        .work          (work_reg),
        .count         (cnt_reg),
        .pattern_bytes (cfg.pattern_bytes),
        .is_prefix     (is_prefix)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign stale        = (cnt_reg >= cfg.pat_len) || !is_prefix;
    assign slot_free    = !out_valid_reg || !result_stall;
    assign emit_ok      = (emit_cnt_reg < CNT_W'(REPL_MAX));
    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = out_last_reg;

    // Pick the byte the current state wants to emit
    always_comb
    begin
        emit_want = 1'b0;
        emit_byte = work_reg[0];
        case (state_reg)
            ST_SCAN:  emit_want = !is_prefix;
            ST_REPL:
            begin
                emit_want = (ri_reg < cfg.rep_len);
                emit_byte = cfg.repl_bytes[{ri_reg[2:0], 3'b000} +: BYTE_W];
            end
            ST_DRAIN: emit_want = (cnt_reg != '0);
            default:  emit_want = 1'b0;
        endcase
    end

    // An emit proceeds once the staging slot can move on; capped bytes just drop
    assign advance = emit_want && (!emit_ok || !pend_valid_reg || slot_free);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        work_next       = work_reg;
        cnt_next        = cnt_reg;
        nl_next         = nl_reg;
        ri_next         = ri_reg;
        emit_cnt_next   = emit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_load        = 1'b0;
        out_load_last   = 1'b0;

        // Stage an emitted byte, pushing the older one out as not last
        if (advance && emit_ok)
        begin
            if (pend_valid_reg)
                out_load = 1'b1;
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
            emit_cnt_next   = emit_cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    emit_cnt_next = '0;
                    if (action)
                        state_next = ST_DRAIN;
                    else
                    begin
                        work_next[cnt_reg[IDX_W-1:0]] = data_byte;
                        cnt_next   = cnt_reg + CNT_W'(1);
                        nl_next    = (data_byte == NEWLINE_BYTE);
                        state_next = stale ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!is_prefix)
                begin
                    if (advance)
                    begin
                        for (int i = 0; i < MAX_PATTERN - 1; i++)
                            work_next[i] = work_reg[i+1];
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                else if (cnt_reg == cfg.pat_len)
                begin
                    cnt_next   = '0;
                    ri_next    = '0;
                    state_next = ST_REPL;
                end
                else if (nl_reg)
                    state_next = ST_DRAIN;
                else
                    state_next = ST_FINISH;
            end
            ST_REPL:
            begin
                if (!emit_want)
                    state_next = ST_FINISH;
                else if (advance)
                    ri_next = ri_reg + CNT_W'(1);
            end
            ST_DRAIN:
            begin
                if (!emit_want)
                    state_next = ST_FINISH;
                else if (advance)
                begin
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                        work_next[i] = work_reg[i+1];
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                // Release the final staged byte with last set
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_load_last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Output register: load from staging or drop on transfer
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && result_stall);
        out_byte_next  = out_load ? pend_byte_reg : out_byte_reg;
        out_last_next  = out_load ? out_load_last : out_last_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            nl_reg         <= 1'b0;
            ri_reg         <= '0;
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            nl_reg         <= nl_next;
            ri_reg         <= ri_next;
            emit_cnt_reg   <= emit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    // Held bytes never reach MAX_PATTERN between items
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg <= CNT_W'(MAX_PATTERN - 1)))
        else $error("held count out of range while idle");

    // No more than eight bytes are staged per item
    a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= CNT_W'(REPL_MAX))
        else $error("emit count above cap");

    // The staging slot is empty whenever a new item can be taken
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("staged byte left over at idle");

    // A flush goes straight to draining the held bytes
    a_flush_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action) |=> (state_reg == ST_DRAIN))
        else $error("flush did not start a drain");

    // A byte loaded into the output register with last set closes the item
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_load_last) |=> (state_reg == ST_IDLE) && !pend_valid_reg)
        else $error("last byte issued before the item finished");

endmodule
